FILE: src/haversine_great_circle_distance_core_defines.svh
// ----------------------------------------------------------------------------
// Haversine core assertion macros
// Shared concurrent check forms, clocked on clk with synchronous reset rst_n.
// ----------------------------------------------------------------------------
`ifndef HAVERSINE_GREAT_CIRCLE_DISTANCE_CORE_DEFINES_SVH
`define HAVERSINE_GREAT_CIRCLE_DISTANCE_CORE_DEFINES_SVH

// Same-cycle implication
`define HGCD_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hgcd: same-cycle check failed");

// Next-cycle implication
`define HGCD_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hgcd: next-cycle check failed");

`endif

FILE: src/hgcd_pkg.sv
// ----------------------------------------------------------------------------
// hgcd_pkg
// Constants, types and helpers shared by the haversine distance pipeline.
// ----------------------------------------------------------------------------
package hgcd_pkg;

  // Fixed-point formats
  localparam int ANGLE_FRAC_BITS = 22;
  localparam int DIST_FRAC_BITS  = 8;

  // Port widths
  localparam int LAT_W    = 30;
  localparam int LON_W    = 31;
  localparam int ARC_W    = 26;
  localparam int RADIUS_W = 16;
  localparam logic [RADIUS_W-1:0] RADIUS_RESET = RADIUS_W'(6371);

  // Angles in half-units (value / 2^(ANGLE_FRAC_BITS+1) degrees)
  localparam int ANG_W  = 33;                   // signed trig input
  localparam int QUAD_W = ANGLE_FRAC_BITS + 8;  // [0, 90 deg] in half-units
  localparam int TURN_W = ANGLE_FRAC_BITS + 10; // [0, 360 deg)
  localparam logic [QUAD_W-1:0] HALF_UNITS_90  = QUAD_W'(90) << (ANGLE_FRAC_BITS + 1);
  localparam logic [TURN_W-1:0] HALF_UNITS_360 = TURN_W'(360) << (ANGLE_FRAC_BITS + 1);

  // Q30 arithmetic
  localparam int Q_FRAC = 30;
  localparam logic [31:0] Q_ONE = 32'd1 << Q_FRAC;
  localparam logic [31:0] PI_Q30 = 32'd3373259426;

  // Half-units to radians: (rem * pi) >> RAD_SHIFT, then divide by 180
  localparam int RAD_SHIFT   = ANGLE_FRAC_BITS + 1;
  localparam int RAD_P_W     = QUAD_W + 32 - RAD_SHIFT;
  localparam int RAD_DIV     = 180;
  localparam int RAD_W       = 31;
  localparam logic [31:0] RAD_RECIP = 32'((64'd1 << RAD_P_W) / RAD_DIV);

  // Taylor series datapath
  localparam int TAYLOR_TERMS = 8;
  localparam int X2_W   = 32;
  localparam int TERM_W = 31;
  localparam int T_W    = 33;
  localparam int SUM_W  = 34;
  localparam int TAY_SHIFT = 36;
  localparam int TAY_RW    = 36;
  localparam int TRIG_W    = 33;
  localparam int TRIG_LAT  = 7 + 3 * TAYLOR_TERMS;

  // Haversine term and search
  localparam int SQ_W = 32;
  localparam int A_W  = 31;
  localparam int BISECT_STEPS = ANGLE_FRAC_BITS + 8;

  localparam logic [ARC_W-1:0] DIST_MAX = '1;

  typedef struct packed {
    logic signed [TRIG_W-1:0] s;
    logic signed [TRIG_W-1:0] c;
  } trig_t;

  // Magnitude of a sine or cosine value
  function automatic logic [TRIG_W-2:0] mag(input logic signed [TRIG_W-1:0] v);
    logic [TRIG_W-2:0] m;
    m = v[TRIG_W-1] ? (TRIG_W-1)'(-v) : (TRIG_W-1)'(v);
    return m;
  endfunction

endpackage

FILE: src/hgcd_trig.sv
// ----------------------------------------------------------------------------
// hgcd_trig
// Pipelined sine/cosine of an angle in half-units: modulo-360 reduction,
// quadrant split, radian conversion and two Q30 Taylor series in parallel.
// ----------------------------------------------------------------------------
module hgcd_trig import hgcd_pkg::*; (
  input  logic                    clk,
  input  logic                    en,
  input  logic signed [ANG_W-1:0] ang_i,
  output trig_t                   trig_o
);

  localparam logic signed [ANG_W+1:0] TURN = (ANG_W+2)'(HALF_UNITS_360);
  localparam logic [TURN_W-1:0] Q1_T = TURN_W'(HALF_UNITS_90);
  localparam logic [TURN_W-1:0] Q2_T = Q1_T + Q1_T;
  localparam logic [TURN_W-1:0] Q3_T = Q2_T + Q1_T;

  logic signed [ANG_W+1:0] v_ext, red;
  logic [TURN_W-1:0]  red_r;
  logic [1:0]         q2_r, q3_r, q4_r, q5_r, q6_r;
  logic [TURN_W-1:0]  rem_t;
  logic [1:0]         q_nxt;
  logic [QUAD_W-1:0]  rem_r;
  logic [QUAD_W+31:0] prod_r;
  logic [RAD_P_W-1:0] p_r;
  logic [RAD_P_W+31:0] est_r;
  logic [31:0]        xe;
  logic [RAD_P_W-1:0] rc;
  logic [RAD_W-1:0]   x5_r, x6_r;
  logic [2*RAD_W-1:0] xsq;
  logic [X2_W-1:0]    x2_r;

  // Per-iteration values of the series
  logic [TERM_W-1:0]       term_s [TAYLOR_TERMS+1];
  logic [TERM_W-1:0]       term_c [TAYLOR_TERMS+1];
  logic signed [SUM_W-1:0] sum_s  [TAYLOR_TERMS+1];
  logic signed [SUM_W-1:0] sum_c  [TAYLOR_TERMS+1];
  logic [X2_W-1:0]         x2_k   [TAYLOR_TERMS+1];
  logic [1:0]              q_k    [TAYLOR_TERMS+1];

  logic signed [TRIG_W-1:0] sb, cb;
  trig_t trig_r;

  // Stage 1: reduce modulo 360 degrees
  assign v_ext = (ANG_W+2)'(ang_i);
  always_comb begin
    if (v_ext >= TURN) begin
      red = v_ext - TURN;
    end else if (v_ext >= 0) begin
      red = v_ext;
    end else if (v_ext >= -TURN) begin
      red = v_ext + TURN;
    end else begin
      red = v_ext + TURN + TURN;
    end
  end

  // Stage 2: quadrant and remainder
  always_comb begin
    if (red_r >= Q3_T) begin
      q_nxt = 2'd3;
      rem_t = red_r - Q3_T;
    end else if (red_r >= Q2_T) begin
      q_nxt = 2'd2;
      rem_t = red_r - Q2_T;
    end else if (red_r >= Q1_T) begin
      q_nxt = 2'd1;
      rem_t = red_r - Q1_T;
    end else begin
      q_nxt = 2'd0;
      rem_t = red_r;
    end
  end

  // Stage 5: reciprocal estimate correction for the divide by 180
  assign xe = est_r[RAD_P_W +: 32];
  assign rc = p_r - RAD_P_W'(xe) * RAD_P_W'(RAD_DIV);
  assign xsq = x5_r * x5_r;

  always_ff @(posedge clk) begin
    if (en) begin
      red_r  <= TURN_W'(red);
      q2_r   <= q_nxt;
      rem_r  <= QUAD_W'(rem_t);
      q3_r   <= q2_r;
      prod_r <= rem_r * PI_Q30;
      q4_r   <= q3_r;
      p_r    <= prod_r[RAD_SHIFT +: RAD_P_W];
      est_r  <= prod_r[RAD_SHIFT +: RAD_P_W] * RAD_RECIP;
      q5_r   <= q4_r;
      x5_r   <= RAD_W'(xe + 32'(rc >= RAD_P_W'(RAD_DIV)));
      q6_r   <= q5_r;
      x6_r   <= x5_r;
      x2_r   <= xsq[Q_FRAC +: X2_W];
    end
  end

  // Series seeds: sin starts at x, cos at one
  assign term_s[0] = TERM_W'(x6_r);
  assign term_c[0] = TERM_W'(Q_ONE);
  assign sum_s[0]  = SUM_W'(x6_r);
  assign sum_c[0]  = SUM_W'(Q_ONE);
  assign x2_k[0]   = x2_r;
  assign q_k[0]    = q6_r;

  // Three stages per term: multiply by x^2, reciprocal multiply, correct and sum
  for (genvar k = 0; k < TAYLOR_TERMS; k++) begin : g_term
    localparam int DS = (2*k + 2) * (2*k + 3);
    localparam int DC = (2*k + 1) * (2*k + 2);
    localparam logic [TAY_RW-1:0] RS = TAY_RW'((64'd1 << TAY_SHIFT) / DS);
    localparam logic [TAY_RW-1:0] RC = TAY_RW'((64'd1 << TAY_SHIFT) / DC);

    logic [TERM_W+X2_W-1:0]  pa_s_r, pa_c_r;
    logic [X2_W-1:0]         xa_r, xb_r, xc_r;
    logic [1:0]              qa_r, qb_r, qc_r;
    logic signed [SUM_W-1:0] sa_s_r, sa_c_r, sb_s_r, sb_c_r, sc_s_r, sc_c_r;
    logic [T_W-1:0]          tb_s_r, tb_c_r;
    logic [T_W+TAY_RW-1:0]   eb_s_r, eb_c_r;
    logic [T_W-1:0]          qe_s, qe_c, rc_s, rc_c;
    logic [TERM_W-1:0]       tn_s, tn_c, tc_s_r, tc_c_r;

    assign qe_s = eb_s_r[TAY_SHIFT +: T_W];
    assign qe_c = eb_c_r[TAY_SHIFT +: T_W];
    assign rc_s = tb_s_r - qe_s * T_W'(DS);
    assign rc_c = tb_c_r - qe_c * T_W'(DC);
    assign tn_s = TERM_W'(qe_s + T_W'(rc_s >= T_W'(DS)));
    assign tn_c = TERM_W'(qe_c + T_W'(rc_c >= T_W'(DC)));

    always_ff @(posedge clk) begin
      if (en) begin
        pa_s_r <= term_s[k] * x2_k[k];
        pa_c_r <= term_c[k] * x2_k[k];
        xa_r   <= x2_k[k];
        qa_r   <= q_k[k];
        sa_s_r <= sum_s[k];
        sa_c_r <= sum_c[k];

        tb_s_r <= pa_s_r[Q_FRAC +: T_W];
        tb_c_r <= pa_c_r[Q_FRAC +: T_W];
        eb_s_r <= pa_s_r[Q_FRAC +: T_W] * RS;
        eb_c_r <= pa_c_r[Q_FRAC +: T_W] * RC;
        xb_r   <= xa_r;
        qb_r   <= qa_r;
        sb_s_r <= sa_s_r;
        sb_c_r <= sa_c_r;

        tc_s_r <= tn_s;
        tc_c_r <= tn_c;
        xc_r   <= xb_r;
        qc_r   <= qb_r;
        // Terms alternate in sign, first correction term subtracts
        if ((k % 2) == 0) begin
          sc_s_r <= sb_s_r - SUM_W'(tn_s);
          sc_c_r <= sb_c_r - SUM_W'(tn_c);
        end else begin
          sc_s_r <= sb_s_r + SUM_W'(tn_s);
          sc_c_r <= sb_c_r + SUM_W'(tn_c);
        end
      end
    end

    assign term_s[k+1] = tc_s_r;
    assign term_c[k+1] = tc_c_r;
    assign sum_s[k+1]  = sc_s_r;
    assign sum_c[k+1]  = sc_c_r;
    assign x2_k[k+1]   = xc_r;
    assign q_k[k+1]    = qc_r;
  end

  // Final stage: place the base values by quadrant
  assign sb = TRIG_W'(sum_s[TAYLOR_TERMS]);
  assign cb = TRIG_W'(sum_c[TAYLOR_TERMS]);

  always_ff @(posedge clk) begin
    if (en) begin
      case (q_k[TAYLOR_TERMS])
        2'd0: begin
          trig_r.s <= sb;
          trig_r.c <= cb;
        end
        2'd1: begin
          trig_r.s <= cb;
          trig_r.c <= -sb;
        end
        2'd2: begin
          trig_r.s <= -sb;
          trig_r.c <= -cb;
        end
        default: begin
          trig_r.s <= -cb;
          trig_r.c <= sb;
        end
      endcase
    end
  end

  assign trig_o = trig_r;

endmodule

FILE: src/haversine_great_circle_distance_core.sv
// ----------------------------------------------------------------------------
// haversine_great_circle_distance_core
// Great-circle distance of two lat/lon points, 2*R*asin(sqrt(a)), in 1/256 km.
// ----------------------------------------------------------------------------
// One point pair enters per clock while in_ready is high. The pipeline depth
// is set by the arcsine search: 30 bisection steps, each running a full
// 31-stage sine pipeline plus a square and a compare stage, behind a front
// end (angle trig, products and the haversine sum) and a tail for radians,
// radius and rounding, then an output register. A stall on the
// result side freezes the pipeline only when a finished result would be lost;
// bubbles inside keep draining. The radius register may be written only while
// no transaction is in flight.
`include "haversine_great_circle_distance_core_defines.svh"

module haversine_great_circle_distance_core import hgcd_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic signed [LAT_W-1:0] in_first_latitude,
  input  logic signed [LON_W-1:0] in_first_longitude,
  input  logic signed [LAT_W-1:0] in_second_latitude,
  input  logic signed [LON_W-1:0] in_second_longitude,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [ARC_W-1:0]        out_arc_distance,
  input  logic                    cfg_wr_en,
  input  logic [RADIUS_W-1:0]     cfg_wr_data
);

  // Stage positions along the valid chain
  localparam int STEP_LAT = TRIG_LAT + 2;
  localparam int P_A      = TRIG_LAT + 3;
  localparam int P_END    = P_A + BISECT_STEPS * STEP_LAT;
  localparam int LAST     = P_END + 5;
  localparam int RND_SH   = Q_FRAC - DIST_FRAC_BITS;
  localparam int DM_W     = RAD_W + RADIUS_W + 1;

  logic [LAST:0] vld_r;
  logic          en;
  logic [RADIUS_W-1:0] radius_r;
  logic          out_valid_r, out_valid_nxt;
  logic [ARC_W-1:0] out_arc_r;

  logic signed [LAT_W-1:0] lat1_r, lat2_r;
  logic signed [LON_W-1:0] lon1_r, lon2_r;
  logic signed [ANG_W-1:0] ang_c1, ang_c2, ang_dlat, ang_dlon;
  trig_t tr_c1, tr_c2, tr_dlat, tr_dlon;

  logic [2*SQ_W-1:0] sqd_p, sqo_p, cc_p, m_p;
  logic [SQ_W-1:0] sqd_r, sqo_r, cc_r, sqd2_r, m_r;
  logic            neg_r, neg2_r;
  logic signed [SQ_W+1:0] asum;
  logic [A_W-1:0] a_r;

  logic [QUAD_W-1:0] lo_w [BISECT_STEPS+1];
  logic [QUAD_W-1:0] hi_w [BISECT_STEPS+1];
  logic [A_W-1:0]    a_w  [BISECT_STEPS+1];

  logic [QUAD_W+31:0]  fprod_r;
  logic [RAD_P_W-1:0]  fp_r;
  logic [RAD_P_W+31:0] fest_r;
  logic [31:0]         fxe;
  logic [RAD_P_W-1:0]  frc;
  logic [RAD_W-1:0]    hrad_r;
  logic [DM_W-1:0]     dm_r;
  logic [DM_W:0]       dsum;
  logic [DM_W:0]       dsh;
  logic [ARC_W-1:0]    dist_r;

  // Pipeline advances unless a finished result would be overwritten
  assign en       = !vld_r[LAST] || !out_valid_r || out_ready;
  assign in_ready = en;

  // Radius register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r <= RADIUS_RESET;
    end else if (cfg_wr_en) begin
      radius_r <= cfg_wr_data;
    end
  end

  // Valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[LAST-1:0], in_valid};
    end
  end

  // Input capture
  always_ff @(posedge clk) begin
    if (en) begin
      lat1_r <= in_first_latitude;
      lon1_r <= in_first_longitude;
      lat2_r <= in_second_latitude;
      lon2_r <= in_second_longitude;
    end
  end

  // Trig angles: cosines at twice the latitude, half differences as is
  assign ang_c1   = ANG_W'(lat1_r) <<< 1;
  assign ang_c2   = ANG_W'(lat2_r) <<< 1;
  assign ang_dlat = ANG_W'(lat2_r) - ANG_W'(lat1_r);
  assign ang_dlon = ANG_W'(lon2_r) - ANG_W'(lon1_r);

  hgcd_trig u_trig_c1   (.clk(clk), .en(en), .ang_i(ang_c1),   .trig_o(tr_c1));
  hgcd_trig u_trig_c2   (.clk(clk), .en(en), .ang_i(ang_c2),   .trig_o(tr_c2));
  hgcd_trig u_trig_dlat (.clk(clk), .en(en), .ang_i(ang_dlat), .trig_o(tr_dlat));
  hgcd_trig u_trig_dlon (.clk(clk), .en(en), .ang_i(ang_dlon), .trig_o(tr_dlon));

  // Haversine term: squares, cosine product, then sum and clamp
  assign sqd_p = mag(tr_dlat.s) * mag(tr_dlat.s);
  assign sqo_p = mag(tr_dlon.s) * mag(tr_dlon.s);
  assign cc_p  = mag(tr_c1.c) * mag(tr_c2.c);
  assign m_p   = cc_r * sqo_r;

  always_comb begin
    if (neg2_r) begin
      asum = (SQ_W+2)'(sqd2_r) - (SQ_W+2)'(m_r);
    end else begin
      asum = (SQ_W+2)'(sqd2_r) + (SQ_W+2)'(m_r);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sqd_r  <= sqd_p[Q_FRAC +: SQ_W];
      sqo_r  <= sqo_p[Q_FRAC +: SQ_W];
      cc_r   <= cc_p[Q_FRAC +: SQ_W];
      neg_r  <= tr_c1.c[TRIG_W-1] ^ tr_c2.c[TRIG_W-1];
      sqd2_r <= sqd_r;
      m_r    <= m_p[Q_FRAC +: SQ_W];
      neg2_r <= neg_r;
      if (asum < 0) begin
        a_r <= '0;
      end else if (asum > (SQ_W+2)'(Q_ONE)) begin
        a_r <= A_W'(Q_ONE);
      end else begin
        a_r <= A_W'(asum);
      end
    end
  end

  // Arcsine by bisection: largest h in [0, 90 deg] with sin^2(h) <= a
  assign lo_w[0] = '0;
  assign hi_w[0] = HALF_UNITS_90;
  assign a_w[0]  = a_r;

  for (genvar b = 0; b < BISECT_STEPS; b++) begin : g_step
    logic [QUAD_W:0]   span;
    logic [QUAD_W-1:0] mid;
    logic [QUAD_W-1:0] dlo_r [TRIG_LAT];
    logic [QUAD_W-1:0] dhi_r [TRIG_LAT];
    logic [QUAD_W-1:0] dmid_r [TRIG_LAT];
    logic [A_W-1:0]    da_r [TRIG_LAT];
    trig_t             tr_mid;
    logic [2*SQ_W-1:0] sq_p;
    logic [SQ_W-1:0]   sq_r;
    logic [QUAD_W-1:0] lo1_r, hi1_r, mid1_r, lo2_r, hi2_r;
    logic [A_W-1:0]    a1_r, a2_r;
    logic              hit;

    assign span = (QUAD_W+1)'(hi_w[b]) - (QUAD_W+1)'(lo_w[b]) + (QUAD_W+1)'(1);
    assign mid  = lo_w[b] + QUAD_W'(span >> 1);

    hgcd_trig u_trig (.clk(clk), .en(en), .ang_i(ANG_W'(mid)), .trig_o(tr_mid));

    assign sq_p = mag(tr_mid.s) * mag(tr_mid.s);
    assign hit  = (sq_r <= SQ_W'(a1_r));

    // Carry the search window alongside the sine pipeline
    always_ff @(posedge clk) begin
      if (en) begin
        dlo_r[0]  <= lo_w[b];
        dhi_r[0]  <= hi_w[b];
        dmid_r[0] <= mid;
        da_r[0]   <= a_w[b];
        for (int i = 1; i < TRIG_LAT; i++) begin
          dlo_r[i]  <= dlo_r[i-1];
          dhi_r[i]  <= dhi_r[i-1];
          dmid_r[i] <= dmid_r[i-1];
          da_r[i]   <= da_r[i-1];
        end
        sq_r   <= sq_p[Q_FRAC +: SQ_W];
        lo1_r  <= dlo_r[TRIG_LAT-1];
        hi1_r  <= dhi_r[TRIG_LAT-1];
        mid1_r <= dmid_r[TRIG_LAT-1];
        a1_r   <= da_r[TRIG_LAT-1];
        // Window update; a closed window passes through unchanged
        lo2_r  <= (lo1_r < hi1_r && hit) ? mid1_r : lo1_r;
        hi2_r  <= (lo1_r < hi1_r && !hit) ? mid1_r - QUAD_W'(1) : hi1_r;
        a2_r   <= a1_r;
      end
    end

    assign lo_w[b+1] = lo2_r;
    assign hi_w[b+1] = hi2_r;
    assign a_w[b+1]  = a2_r;
  end

  // Tail: half angle to radians, times 2R, round and saturate
  assign fxe  = fest_r[RAD_P_W +: 32];
  assign frc  = fp_r - RAD_P_W'(fxe) * RAD_P_W'(RAD_DIV);
  assign dsum = (DM_W+1)'(dm_r) + ((DM_W+1)'(1) << (RND_SH - 1));
  assign dsh  = dsum >> RND_SH;

  always_ff @(posedge clk) begin
    if (en) begin
      fprod_r <= lo_w[BISECT_STEPS] * PI_Q30;
      fp_r    <= fprod_r[RAD_SHIFT +: RAD_P_W];
      fest_r  <= fprod_r[RAD_SHIFT +: RAD_P_W] * RAD_RECIP;
      hrad_r  <= RAD_W'(fxe + 32'(frc >= RAD_P_W'(RAD_DIV)));
      dm_r    <= hrad_r * {radius_r, 1'b0};
      if (dsh > (DM_W+1)'(DIST_MAX)) begin
        dist_r <= DIST_MAX;
      end else begin
        dist_r <= ARC_W'(dsh);
      end
    end
  end

  // Output register
  assign out_valid_nxt = (out_ready || !out_valid_r) ? vld_r[LAST] : out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if ((out_ready || !out_valid_r) && vld_r[LAST]) begin
      out_arc_r <= dist_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_arc_distance = out_arc_r;

  // Checks
  `HGCD_ASSERT_NOW(a_clamped, vld_r[P_A], a_w[0] <= A_W'(Q_ONE))
  `HGCD_ASSERT_NOW(search_closed, vld_r[P_END], lo_w[BISECT_STEPS] == hi_w[BISECT_STEPS])
  `HGCD_ASSERT_NOW(ready_when_free, !out_valid_r || out_ready, in_ready)
  `HGCD_ASSERT_NEXT(stall_holds, out_valid_r && !out_ready && vld_r[LAST], out_valid_r && vld_r[LAST])

endmodule
